### design/distance_vector_parse_update_defines.svh
// Assertion macros shared by the distance vector update design.
`ifndef DISTANCE_VECTOR_PARSE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_PARSE_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge.
`define DVPU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define DVPU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DVPU_ASSERT_IMP(label, clk, rst, ante, cons)
`define DVPU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/dvpu_pkg.sv
// Types, codes and helper functions of the distance vector update design.
`timescale 1ns / 1ps
package dvpu_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Operation codes of an input transfer.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CHAR = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Message delimiters and digit bounds.
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [14:0] SAT_MAX = 15'h7FFF;

   typedef struct packed {
      logic [15:0] origin;
      logic [15:0] destination;
      logic [15:0] weight;
   } entry_type;

   // A finished pair as seen by the parser, before the message state clears.
   typedef struct packed {
      logic        fire;
      logic [14:0] dest;
      logic [14:0] weight;
      logic [14:0] sender;
   } pair_type;

   // What the head of the ring needs to know about the running operation.
   typedef struct packed {
      logic [1:0]  op;
      logic        idx_hit;
      entry_type   load;
      logic [14:0] dest;
      logic [14:0] weight;
      logic [14:0] sender;
   } scan_type;

   typedef struct packed {
      entry_type next;
      logic      read_hit;
      logic      updated;
   } head_type;

   // acc * 10 + digit, saturated to the largest positive 16-bit value.
   function automatic logic [14:0] sat_digit(input logic [14:0] acc,
                                             input logic [3:0]  digit);
      logic [18:0] sum;
      sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {15'd0, digit};
      return (sum > {4'd0, SAT_MAX}) ? SAT_MAX : sum[14:0];
   endfunction

endpackage

### design/dvpu_if.sv
// Request and response channel interfaces of the distance vector update design.
`timescale 1ns / 1ps
interface dvpu_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [5:0]        entry_index;
   logic signed [15:0] entry_origin;
   logic signed [15:0] entry_destination;
   logic signed [15:0] entry_weight;
   logic [7:0]        char_byte;
   logic              last_char;

   modport source (output valid, opcode, entry_index, entry_origin, entry_destination,
                   entry_weight, char_byte, last_char, input ready);
   modport sink (input valid, opcode, entry_index, entry_origin, entry_destination,
                 entry_weight, char_byte, last_char, output ready);
endinterface

interface dvpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] read_origin;
   logic signed [15:0] read_destination;
   logic signed [15:0] read_weight;
   logic               pair_complete;
   logic [14:0]        pair_destination;
   logic [14:0]        pair_weight;
   logic [6:0]         entries_updated;

   modport source (output valid, read_origin, read_destination, read_weight,
                   pair_complete, pair_destination, pair_weight, entries_updated,
                   input ready);
   modport sink (input valid, read_origin, read_destination, read_weight,
                 pair_complete, pair_destination, pair_weight, entries_updated,
                 output ready);
endinterface

### design/dvpu_cell.sv
// One routing table entry, held in a cell of the rotating ring.
`timescale 1ns / 1ps
module dvpu_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  dvpu_pkg::entry_type din,
   output dvpu_pkg::entry_type dout
);

   dvpu_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = shift ? din : entry_ff;
   end

   // An empty entry reads as all ones in every field.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '1;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign dout = entry_ff;

endmodule

### design/dvpu_head.sv
// Work done on the entry passing the head of the ring: load, read or pair update.
`timescale 1ns / 1ps
module dvpu_head (
   input  dvpu_pkg::entry_type cur,
   input  dvpu_pkg::scan_type  ctrl,
   output dvpu_pkg::head_type  result
);

   logic dest_match;
   logic heavier;

   always_comb begin
      dest_match = cur.destination == {1'b0, ctrl.dest};
      heavier    = $signed(cur.weight) > $signed({1'b0, ctrl.weight});
      result.next     = cur;
      result.read_hit = 1'b0;
      result.updated  = 1'b0;
      case (ctrl.op)
         dvpu_pkg::OP_LOAD: begin
            if (ctrl.idx_hit) begin
               result.next = ctrl.load;
            end
         end
         dvpu_pkg::OP_READ: begin
            result.read_hit = ctrl.idx_hit;
         end
         dvpu_pkg::OP_CHAR: begin
            if (dest_match && heavier) begin
               result.next.weight = {1'b0, ctrl.weight};
               result.next.origin = {1'b0, ctrl.sender};
               result.updated     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### design/dvpu_parser.sv
// Character parser: sender id from the header, destination and weight pairs from the body.
`timescale 1ns / 1ps
module dvpu_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         char_byte,
   input  logic               last_char,
   output dvpu_pkg::pair_type pair
);

   // Position within the message.
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_BODY   = 2'd2;
   localparam logic [1:0] POS_SKIP   = 2'd3;

   // Capture mode bits.
   localparam logic [1:0] MODE_DEST   = 2'b01;
   localparam logic [1:0] MODE_WEIGHT = 2'b10;

   logic [1:0]  pos_ff, pos_in;
   logic [14:0] sender_ff, sender_in;
   logic [1:0]  mode_ff, mode_in;
   logic [14:0] accum_ff, accum_in;
   logic [14:0] pend_ff, pend_in;
   logic        is_digit;
   logic [3:0]  digit;
   logic [14:0] accum_dig;

   always_comb begin
      is_digit  = char_byte inside {[dvpu_pkg::CH_ZERO:dvpu_pkg::CH_NINE]};
      digit     = is_digit ? char_byte[3:0] : 4'd0;
      accum_dig = ((mode_ff != 2'd0) && is_digit) ?
                  dvpu_pkg::sat_digit(accum_ff, digit) : accum_ff;
      pos_in    = pos_ff;
      sender_in = sender_ff;
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      pend_in   = pend_ff;
      pair.fire   = 1'b0;
      pair.dest   = pend_ff;
      pair.weight = accum_dig;
      pair.sender = sender_ff;
      case (pos_ff)
         POS_FIRST: begin
            if (is_digit) begin
               sender_in = {11'd0, digit};
               pos_in    = POS_SECOND;
            end else begin
               sender_in = '0;
               pos_in    = POS_SKIP;
            end
         end
         POS_SECOND: begin
            if (is_digit) begin
               sender_in = dvpu_pkg::sat_digit(sender_ff, digit);
            end
            pos_in = POS_BODY;
         end
         POS_SKIP: begin
            pos_in = POS_BODY;
         end
         default: begin
            accum_in = accum_dig;
            case (char_byte)
               dvpu_pkg::CH_OPEN: begin
                  mode_in = mode_ff | MODE_DEST;
               end
               dvpu_pkg::CH_COMMA: begin
                  pend_in  = accum_dig;
                  accum_in = '0;
                  mode_in  = MODE_WEIGHT;
               end
               dvpu_pkg::CH_CLOSE: begin
                  accum_in  = '0;
                  mode_in   = mode_ff & MODE_DEST;
                  pair.fire = 1'b1;
               end
               default: begin
               end
            endcase
         end
      endcase
      // The last character of a message leaves a clean parse state behind.
      if (last_char) begin
         pos_in    = POS_FIRST;
         sender_in = '0;
         mode_in   = '0;
         accum_in  = '0;
         pend_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_FIRST;
         sender_ff <= '0;
         mode_ff   <= '0;
         accum_ff  <= '0;
         pend_ff   <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         sender_ff <= sender_in;
         mode_ff   <= mode_in;
         accum_ff  <= accum_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

### design/distance_vector_parse_update.sv
// Top level of the distance vector routing table and message parser.
//
// Channel   Direction  Contents
// req_ch    in         opcode, slot and entry fields to load, message character, last flag
// rsp_ch    out        read-back entry, finished pair and number of entries replaced
//
// A load, a read or a closing parenthesis makes a full pass over the table: the table
// lives in a ring of TABLE_DEPTH cells that turns once, one entry past the head
// unit per cycle. Every other character is answered without a pass.
// Reset is synchronous; the table comes out of it with all fields set to -1 at once.
// A stalled response holds its register; a new request is taken only when the ring
// is at rest and the response register is empty or being transferred.
`timescale 1ns / 1ps
`include "distance_vector_parse_update_defines.svh"
module distance_vector_parse_update #(
   parameter int TABLE_DEPTH = dvpu_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   dvpu_req_if.sink          req_ch,
   dvpu_rsp_if.source        rsp_ch
);

   // Step counter width, and a width that holds both the counter and a slot index.
   localparam int CNT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW    = (CNT_W > 6) ? CNT_W : 6;

   logic                 accept;
   logic                 needs_scan;
   logic                 last_step;
   dvpu_pkg::pair_type   pair;
   dvpu_pkg::scan_type   ctrl;
   dvpu_pkg::head_type   head;
   dvpu_pkg::entry_type  cell_in  [TABLE_DEPTH];
   dvpu_pkg::entry_type  cell_out [TABLE_DEPTH];

   // Ring control and the operation being carried round.
   logic                 scan_ff, scan_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           op_ff, op_in;
   logic [5:0]           idx_ff, idx_in;
   dvpu_pkg::entry_type  load_ff, load_in;
   logic [14:0]          pdest_ff, pdest_in;
   logic [14:0]          pweight_ff, pweight_in;
   logic [14:0]          psender_ff, psender_in;
   dvpu_pkg::entry_type  rd_ff, rd_in, rd_next;
   logic [6:0]           count_ff, count_in, count_next;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   dvpu_pkg::entry_type  rsp_entry_ff, rsp_entry_in;
   logic                 rsp_pair_ff, rsp_pair_in;
   logic [14:0]          rsp_dest_ff, rsp_dest_in;
   logic [14:0]          rsp_weight_ff, rsp_weight_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;

   assign req_ch.ready = !scan_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   // The parser commits its state on every accepted character transfer; the pair it
   // reports is taken before an end-of-message clear wipes the sender id.
   dvpu_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (accept && (req_ch.opcode == dvpu_pkg::OP_CHAR)),
      .char_byte (req_ch.char_byte),
      .last_char (req_ch.last_char),
      .pair      (pair)
   );

   // The entry at cell 0 is the one whose slot equals the step counter, because the
   // ring starts each pass aligned and moves one place towards cell 0 per cycle.
   always_comb begin
      ctrl.op      = op_ff;
      ctrl.idx_hit = IW'(idx_ff) == IW'(cnt_ff);
      ctrl.load    = load_ff;
      ctrl.dest    = pdest_ff;
      ctrl.weight  = pweight_ff;
      ctrl.sender  = psender_ff;
   end

   dvpu_head u_head (
      .cur    (cell_out[0]),
      .ctrl   (ctrl),
      .result (head)
   );

   // The processed head entry re-enters the ring at the far end.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign cell_in[i] = head.next;
      end else begin : g_link
         assign cell_in[i] = cell_out[i+1];
      end
      dvpu_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (scan_ff),
         .din   (cell_in[i]),
         .dout  (cell_out[i])
      );
   end

   always_comb begin
      needs_scan = (req_ch.opcode == dvpu_pkg::OP_LOAD) ||
                   (req_ch.opcode == dvpu_pkg::OP_READ) ||
                   ((req_ch.opcode == dvpu_pkg::OP_CHAR) && pair.fire);
      last_step  = cnt_ff == CNT_W'(TABLE_DEPTH - 1);
      rd_next    = head.read_hit ? cell_out[0] : rd_ff;
      count_next = (head.updated && (count_ff != 7'h7F)) ? count_ff + 7'd1 : count_ff;

      scan_in    = scan_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      load_in    = load_ff;
      pdest_in   = pdest_ff;
      pweight_in = pweight_ff;
      psender_in = psender_ff;
      rd_in      = rd_ff;
      count_in   = count_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_count_in  = rsp_count_ff;

      if (accept) begin
         op_in              = req_ch.opcode;
         idx_in             = req_ch.entry_index;
         load_in.origin      = req_ch.entry_origin;
         load_in.destination = req_ch.entry_destination;
         load_in.weight      = req_ch.entry_weight;
         pdest_in   = pair.dest;
         pweight_in = pair.weight;
         psender_in = pair.sender;
         if (needs_scan) begin
            scan_in  = 1'b1;
            cnt_in   = '0;
            // A read of a slot beyond the table finds no hit and answers all ones.
            rd_in    = (req_ch.opcode == dvpu_pkg::OP_READ) ? '1 : '0;
            count_in = '0;
         end else begin
            // Characters that close no pair, and the unused opcode, answer zeros.
            rsp_valid_in  = 1'b1;
            rsp_entry_in  = '0;
            rsp_pair_in   = 1'b0;
            rsp_dest_in   = '0;
            rsp_weight_in = '0;
            rsp_count_in  = '0;
         end
      end

      if (scan_ff) begin
         cnt_in   = cnt_ff + CNT_W'(1);
         rd_in    = rd_next;
         count_in = count_next;
         if (last_step) begin
            scan_in      = 1'b0;
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_entry_in = rd_next;
            rsp_pair_in  = op_ff == dvpu_pkg::OP_CHAR;
            rsp_dest_in   = (op_ff == dvpu_pkg::OP_CHAR) ? pdest_ff : '0;
            rsp_weight_in = (op_ff == dvpu_pkg::OP_CHAR) ? pweight_ff : '0;
            rsp_count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operands and results carry no reset; they are written before they are used.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      load_ff       <= load_in;
      pdest_ff      <= pdest_in;
      pweight_ff    <= pweight_in;
      psender_ff    <= psender_in;
      rd_ff         <= rd_in;
      count_ff      <= count_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.read_origin      = rsp_entry_ff.origin;
   assign rsp_ch.read_destination = rsp_entry_ff.destination;
   assign rsp_ch.read_weight      = rsp_entry_ff.weight;
   assign rsp_ch.pair_complete    = rsp_pair_ff;
   assign rsp_ch.pair_destination = rsp_dest_ff;
   assign rsp_ch.pair_weight      = rsp_weight_ff;
   assign rsp_ch.entries_updated  = rsp_count_ff;

   // A table operation starts the ring turning from step zero.
   `DVPU_ASSERT_NEXT(a_scan_starts, clock, reset, accept && needs_scan, scan_ff && (cnt_ff == '0))
   // The final step of a pass stops the ring and presents the response.
   `DVPU_ASSERT_NEXT(a_scan_ends, clock, reset, scan_ff && last_step, !scan_ff && rsp_valid_ff)
   // While the ring turns, nothing is taken and the response register stays empty.
   `DVPU_ASSERT_IMP(a_quiet_in_scan, clock, reset, scan_ff, !req_ch.ready && !rsp_valid_ff)
   // Only a finished pair can report replaced entries.
   `DVPU_ASSERT_IMP(a_count_pair, clock, reset, rsp_valid_ff && !rsp_pair_ff, rsp_count_ff == '0)

endmodule
